@@ src/sha256_stream_hash_core_macros.svh @@
// assertion macros shared by the checker
`ifndef SHA256_STREAM_HASH_CORE_MACROS_SVH
`define SHA256_STREAM_HASH_CORE_MACROS_SVH

// property checked only while out of reset
`define SHA_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also covers the reset cycles
`define SHA_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/sha256_pkg.sv @@
`default_nettype none
package sha256_pkg;

   localparam int ROUNDS     = 64;
   localparam int RND_W      = $clog2(ROUNDS);
   localparam int BUF_WORDS  = 16;
   localparam int BUF_AW     = $clog2(BUF_WORDS);
   localparam int CMD_DEPTH  = 4;
   localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W  = CMD_PTR_W + 1;

   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [5:0] LAST_POS    = 6'd63;
   localparam logic [2:0] LAST_INDEX  = 3'd7;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_BYTE_LAST,
      CMD_LAST
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } back_state_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] major(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage
`default_nettype wire

@@ src/sha256_req_if.sv @@
`default_nettype none
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, data_byte, has_byte, last, input ready);
   modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface
`default_nettype wire

@@ src/sha256_rsp_if.sv @@
`default_nettype none
interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

@@ src/sha256_ram.sv @@
`default_nettype none
module sha256_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

@@ src/sha256_front.sv @@
`default_nettype none
module sha256_front import sha256_pkg::*; (
   sha256_req_if.sink req_port,
   output logic       push_valid,
   input  wire logic  push_ready,
   output cmd_type    push_cmd
);

   // items with neither a byte nor the last flag are taken and dropped
   assign req_port.ready = push_ready;
   assign push_valid     = req_port.valid && (req_port.has_byte || req_port.last);

   always_comb begin
      push_cmd.data = req_port.data_byte;
      if (!req_port.last) begin
         push_cmd.kind = CMD_BYTE;
      end else if (req_port.has_byte) begin
         push_cmd.kind = CMD_BYTE_LAST;
      end else begin
         push_cmd.kind = CMD_LAST;
      end
   end

endmodule
`default_nettype wire

@@ src/sha256_cmd_fifo.sv @@
`default_nettype none
module sha256_cmd_fifo import sha256_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_cmd
);

   cmd_type                slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   push, pop;

   assign push_ready = count_ff != CMD_CNT_W'(CMD_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ src/sha256_back.sv @@
`default_nettype none
module sha256_back import sha256_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_ready,
   input  wire cmd_type cmd,
   sha256_rsp_if.source rsp_port
);

   back_state_type   state_ff, state_in;
   logic [5:0]       pos_ff, pos_in;
   logic [63:0]      count_ff, count_in;
   logic [23:0]      word_ff, word_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic [2:0]       idx_ff, idx_in;
   logic             pad_ff, pad_in;
   logic             first_ff, first_in;
   logic             wrap_ff, wrap_in;
   logic             done_ff, done_in;
   logic [31:0]      chain_ff [8];
   logic [31:0]      chain_in [8];
   logic [31:0]      v_ff [8];
   logic [31:0]      v_in [8];
   logic [31:0]      win_ff [16];
   logic [31:0]      win_in [16];

   logic             pop;
   logic             wr_byte;
   logic             msg_byte;
   logic [7:0]       wr_data;
   logic [7:0]       pad_byte;
   logic [63:0]      bit_len;
   logic             ram_we;
   logic [BUF_AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]      ram_rdata;
   logic [31:0]      w_cur, t1, t2;
   logic             rsp_take;

   sha256_ram #(.WIDTH(32), .DEPTH(BUF_WORDS)) u_buf (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({word_ff, wr_data}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // padding byte: marker first, then zeros, then the bit length at 56..63
   assign bit_len = {count_ff[60:0], 3'b000};
   always_comb begin
      if (first_ff) begin
         pad_byte = PAD_MARK;
      end else if (pos_ff >= LEN_POS && !wrap_ff) begin
         pad_byte = 8'(bit_len >> {~pos_ff[2:0], 3'b000});
      end else begin
         pad_byte = 8'h00;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_LAST:      state_in = ST_PAD;
                  CMD_BYTE_LAST: state_in = (pos_ff == LAST_POS) ? ST_LOAD : ST_PAD;
                  default:       state_in = (pos_ff == LAST_POS) ? ST_LOAD : ST_IDLE;
               endcase
            end
         end
         ST_PAD:   state_in = (pos_ff == LAST_POS) ? ST_LOAD : ST_PAD;
         ST_LOAD:  state_in = ST_ROUND;
         ST_ROUND: state_in = (rnd_ff == RND_W'(ROUNDS - 1)) ? ST_FOLD : ST_ROUND;
         ST_FOLD:  state_in = !pad_ff ? ST_IDLE : (done_ff ? ST_OUT : ST_PAD);
         ST_OUT:   state_in = (rsp_port.ready && idx_ff == LAST_INDEX) ? ST_IDLE : ST_OUT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_ready = 1'b0;
      wr_byte   = 1'b0;
      msg_byte  = 1'b0;
      wr_data   = pad_byte;
      ram_raddr = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            wr_data   = cmd.data;
            if (cmd_valid && cmd.kind != CMD_LAST) begin
               wr_byte  = 1'b1;
               msg_byte = 1'b1;
            end
         end
         ST_PAD:   wr_byte   = 1'b1;
         ST_ROUND: ram_raddr = rnd_ff[BUF_AW-1:0] + 1'b1;
         default: begin
         end
      endcase
   end

   assign pop       = cmd_valid && cmd_ready;
   assign ram_we    = wr_byte && pos_ff[1:0] == 2'b11;
   assign ram_waddr = pos_ff[5:2];
   assign rsp_take  = rsp_port.valid && rsp_port.ready;

   assign rsp_port.valid       = state_ff == ST_OUT;
   assign rsp_port.digest_word = chain_ff[idx_ff];
   assign rsp_port.word_index  = idx_ff;
   assign rsp_port.last_word   = idx_ff == LAST_INDEX;

   // round datapath
   always_comb begin
      if (rnd_ff < RND_W'(BUF_WORDS)) begin
         w_cur = ram_rdata;
      end else begin
         w_cur = win_ff[0] + small_sig0(win_ff[1]) + win_ff[9] + small_sig1(win_ff[14]);
      end
      t1 = v_ff[7] + big_sig1(v_ff[4]) + choose(v_ff[4], v_ff[5], v_ff[6])
           + ROUND_K[rnd_ff] + w_cur;
      t2 = big_sig0(v_ff[0]) + major(v_ff[0], v_ff[1], v_ff[2]);
   end

   // register next values
   always_comb begin
      pos_in   = pos_ff;
      count_in = count_ff;
      word_in  = word_ff;
      rnd_in   = rnd_ff;
      idx_in   = idx_ff;
      pad_in   = pad_ff;
      first_in = first_ff;
      wrap_in  = wrap_ff;
      done_in  = done_ff;
      chain_in = chain_ff;
      v_in     = v_ff;
      win_in   = win_ff;

      if (wr_byte) begin
         pos_in  = pos_ff + 1'b1;
         word_in = {word_ff[15:0], wr_data};
      end
      if (msg_byte) begin
         count_in = count_ff + 64'd1;
      end
      if (pop && cmd.kind != CMD_BYTE) begin
         pad_in   = 1'b1;
         first_in = 1'b1;
      end

      case (state_ff)
         ST_PAD: begin
            first_in = 1'b0;
            // marker too late for the length: one more block of zeros first
            if (first_ff && pos_ff >= LEN_POS) begin
               wrap_in = 1'b1;
            end
            if (pos_ff == LAST_POS && !first_ff && !wrap_ff) begin
               done_in = 1'b1;
            end
         end
         ST_LOAD: begin
            rnd_in = '0;
            v_in   = chain_ff;
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 1'b1;
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = w_cur;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
         end
         ST_FOLD: begin
            wrap_in = 1'b0;
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
         end
         ST_OUT: begin
            if (rsp_take) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_INDEX) begin
                  chain_in = INIT_HASH;
                  count_in = '0;
                  pad_in   = 1'b0;
                  done_in  = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         pad_ff   <= 1'b0;
         first_ff <= 1'b0;
         wrap_ff  <= 1'b0;
         done_ff  <= 1'b0;
         chain_ff <= INIT_HASH;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
         pad_ff   <= pad_in;
         first_ff <= first_in;
         wrap_ff  <= wrap_in;
         done_ff  <= done_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      v_ff    <= v_in;
      win_ff  <= win_in;
   end

endmodule
`default_nettype wire

@@ src/sha256_stream_hash_core.sv @@
// sha-256 over a byte stream: one byte per req word, digest as eight rsp words
// message bytes: written into the block buffer by the back end while idle; each full 64-byte block then
// runs one load, the rounds on the single round unit and one chain fold, and takes no bytes meanwhile
// last word: padding bytes through the length field, plus one or two compressions, then 8 digest words
// reset (synchronous): queue empty, count zero, chain at the initial hash, buffer not cleared
`default_nettype none
module sha256_stream_hash_core import sha256_pkg::*; (
   input wire logic     clock,
   input wire logic     reset,
   sha256_req_if.sink   req_port,
   sha256_rsp_if.source rsp_port
);

   // front end to queue
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;

   // queue to back end
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   // front: takes req words while the queue has room, drops empty ones, tags bytes and message ends
   sha256_front u_front (
      .req_port   (req_port),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // short queue so req words keep flowing while the round unit is busy, until the queue is full
   sha256_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_cmd    (cmd)
   );

   // back: block buffer, padding sequencer, round unit and digest output
   sha256_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_port  (rsp_port)
   );

endmodule
`default_nettype wire

@@ src/sha256_checker.sv @@
`default_nettype none
`include "sha256_stream_hash_core_macros.svh"
module sha256_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);

   `SHA_CHECK(rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word) && $stable(rsp_word_index), "stalled digest word changed")
   `SHA_CHECK(rsp_last_flag, clock, reset, rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)), "last_word out of step with word_index")
   `SHA_CHECK(rsp_advance, clock, reset, rsp_valid && rsp_ready && !rsp_last_word |=> rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1), "digest words not back to back in order")
   `SHA_CHECK_ALWAYS(rsp_after_reset, clock, reset |=> !rsp_valid && (rsp_word_index == 3'd0), "digest output not idle after reset")

endmodule

bind sha256_stream_hash_core sha256_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_digest_word (rsp_port.digest_word),
   .rsp_word_index  (rsp_port.word_index),
   .rsp_last_word   (rsp_port.last_word)
);
`default_nettype wire
